// File: design/bdcm_pkg.sv
// Shared types and constants of the button debounce command mapper.
package bdcm_pkg;

    localparam int unsigned NUM_BUTTONS = 4;
    localparam int unsigned TIME_W      = 32;
    localparam int unsigned CFG_W       = 16;
    localparam int unsigned CMD_W       = 3;
    localparam int unsigned MODE_W      = 2;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam int unsigned KEY_VOL_DN = 0;
    localparam int unsigned KEY_PAUSE  = 1;
    localparam int unsigned KEY_PLAY   = 2;
    localparam int unsigned KEY_VOL_UP = 3;

    localparam logic [CMD_W-1:0] OP_VOL_DN = 3'd0;
    localparam logic [CMD_W-1:0] OP_STOP   = 3'd1;
    localparam logic [CMD_W-1:0] OP_PAUSE  = 3'd2;
    localparam logic [CMD_W-1:0] OP_RESUME = 3'd3;
    localparam logic [CMD_W-1:0] OP_NEXT   = 3'd4;
    localparam logic [CMD_W-1:0] OP_PLAY   = 3'd5;
    localparam logic [CMD_W-1:0] OP_VOL_UP = 3'd6;

    localparam logic [MODE_W-1:0] MODE_PLAYING = 2'd1;
    localparam logic [MODE_W-1:0] MODE_PAUSED  = 2'd2;

    localparam logic       CFG_IDX_DEBOUNCE     = 1'b0;
    localparam logic       CFG_IDX_DOUBLE_CLICK = 1'b1;
    localparam logic [CFG_W-1:0] DEBOUNCE_RESET     = 16'd50;
    localparam logic [CFG_W-1:0] DOUBLE_CLICK_RESET = 16'd500;

    typedef struct packed {
        logic              press;
        logic [TIME_W-1:0] delta;
    } lane_status_t;

    typedef struct packed {
        logic [NUM_BUTTONS-1:0] mask;
        logic [CMD_W-1:0]       pause_cmd;
        logic [CMD_W-1:0]       play_cmd;
    } tick_entry_t;

endpackage

// File: design/button_debounce_command_mapper_unit.sv
// Top level of the button debounce command mapper: config registers, lanes, merge.
// Latency: a tick transferred at edge N with no earlier command waiting shows its first
// command in the cycle after edge N.
// Throughput: one tick per cycle while m_tready is high, when it yields one command or none;
// otherwise one command per cycle on the output while m_tready is high, a tick's commands in turn.
// Reset (rst_n low, asynchronous): flags and press times clear, config returns to 50/500.
module button_debounce_command_mapper_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // level_vol_down, level_pause, level_play, level_vol_up,
                                   // now_ms[31:0], player_mode[1:0], zero pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // command[2:0], zero pad
    output logic        m_tlast,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_data
);

    logic [bdcm_pkg::CFG_W-1:0]  debounce_reg;
    logic [bdcm_pkg::CFG_W-1:0]  double_click_reg;
    logic                        tick;
    logic [bdcm_pkg::TIME_W-1:0] now_ms;
    logic [bdcm_pkg::MODE_W-1:0] player_mode;
    logic [bdcm_pkg::CMD_W-1:0]  cmd;
    bdcm_pkg::lane_status_t [bdcm_pkg::NUM_BUTTONS-1:0] lanes;

    assign tick        = s_tvalid && s_tready;
    assign now_ms      = s_tdata[35:4];
    assign player_mode = s_tdata[37:36];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg     <= bdcm_pkg::DEBOUNCE_RESET;
            double_click_reg <= bdcm_pkg::DOUBLE_CLICK_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                bdcm_pkg::CFG_IDX_DEBOUNCE:     debounce_reg     <= cfg_data;
                bdcm_pkg::CFG_IDX_DOUBLE_CLICK: double_click_reg <= cfg_data;
                default:                        debounce_reg     <= debounce_reg;
            endcase
        end
    end

    for (genvar i = 0; i < bdcm_pkg::NUM_BUTTONS; i++)
    begin : g_lane
        bdcm_lane u_lane
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .tick        (tick),
            .level       (s_tdata[i]),
            .now_ms      (now_ms),
            .debounce_ms (debounce_reg),
            .status      (lanes[i])
        );
    end

    bdcm_merge u_merge
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .tick            (tick),
        .lanes           (lanes),
        .player_mode     (player_mode),
        .double_click_ms (double_click_reg),
        .room            (s_tready),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_cmd         (cmd),
        .out_last        (m_tlast)
    );

    assign m_tdata = {5'b00000, cmd};

endmodule

// File: design/bdcm_lane.sv
// Debounce lane for one button: latched flag, last press time and press test.
module bdcm_lane
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                tick,
    input  logic                                level,
    input  logic [bdcm_pkg::TIME_W-1:0]         now_ms,
    input  logic [bdcm_pkg::CFG_W-1:0]          debounce_ms,
    output bdcm_pkg::lane_status_t              status
);

    logic                        flag_reg;
    logic                        flag_next;
    logic [bdcm_pkg::TIME_W-1:0] time_reg;
    logic [bdcm_pkg::TIME_W-1:0] time_next;
    logic [bdcm_pkg::TIME_W-1:0] delta;
    logic                        press;

    assign delta = now_ms - time_reg;
    assign press = level && !flag_reg
                   && (delta > {{(bdcm_pkg::TIME_W-bdcm_pkg::CFG_W){1'b0}}, debounce_ms});

    always_comb
    begin
        flag_next = flag_reg;
        time_next = time_reg;
        if (tick)
        begin
            if (!level)
            begin
                flag_next = 1'b0;
            end
            else if (press)
            begin
                flag_next = 1'b1;
                time_next = now_ms;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flag_reg <= 1'b0;
            time_reg <= '0;
        end
        else
        begin
            flag_reg <= flag_next;
            time_reg <= time_next;
        end
    end

    assign status.press = press;
    assign status.delta = delta;

endmodule

// File: design/bdcm_merge.sv
// Merge of lane presses into commands, tick queue and serial command output.
module bdcm_merge
(
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          tick,
    input  bdcm_pkg::lane_status_t [bdcm_pkg::NUM_BUTTONS-1:0] lanes,
    input  logic [bdcm_pkg::MODE_W-1:0]                   player_mode,
    input  logic [bdcm_pkg::CFG_W-1:0]                    double_click_ms,
    output logic                                          room,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic [bdcm_pkg::CMD_W-1:0]                    out_cmd,
    output logic                                          out_last
);

    localparam int unsigned PTR_W = (bdcm_pkg::QUEUE_DEPTH > 1)
                                    ? $clog2(bdcm_pkg::QUEUE_DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(bdcm_pkg::QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(bdcm_pkg::QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(bdcm_pkg::QUEUE_DEPTH - 1);

    bdcm_pkg::tick_entry_t  entry_reg [bdcm_pkg::QUEUE_DEPTH];
    bdcm_pkg::tick_entry_t  new_entry;
    bdcm_pkg::tick_entry_t  head;
    logic [PTR_W-1:0]       wr_ptr_reg;
    logic [PTR_W-1:0]       rd_ptr_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic                   pause_ok;
    logic                   push;
    logic                   out_fire;
    logic                   pop;
    logic [bdcm_pkg::NUM_BUTTONS-1:0] sel;
    logic [bdcm_pkg::NUM_BUTTONS-1:0] rest;

    always_comb
    begin
        new_entry.pause_cmd = bdcm_pkg::OP_STOP;
        pause_ok            = 1'b1;
        if (lanes[bdcm_pkg::KEY_PAUSE].delta
            < {{(bdcm_pkg::TIME_W-bdcm_pkg::CFG_W){1'b0}}, double_click_ms})
        begin
            new_entry.pause_cmd = bdcm_pkg::OP_STOP;
        end
        else if (player_mode == bdcm_pkg::MODE_PLAYING)
        begin
            new_entry.pause_cmd = bdcm_pkg::OP_PAUSE;
        end
        else if (player_mode == bdcm_pkg::MODE_PAUSED)
        begin
            new_entry.pause_cmd = bdcm_pkg::OP_RESUME;
        end
        else
        begin
            pause_ok = 1'b0;
        end
        new_entry.play_cmd = (player_mode == bdcm_pkg::MODE_PLAYING)
                             ? bdcm_pkg::OP_NEXT : bdcm_pkg::OP_PLAY;
        new_entry.mask[bdcm_pkg::KEY_VOL_DN] = lanes[bdcm_pkg::KEY_VOL_DN].press;
        new_entry.mask[bdcm_pkg::KEY_PAUSE]  = lanes[bdcm_pkg::KEY_PAUSE].press && pause_ok;
        new_entry.mask[bdcm_pkg::KEY_PLAY]   = lanes[bdcm_pkg::KEY_PLAY].press;
        new_entry.mask[bdcm_pkg::KEY_VOL_UP] = lanes[bdcm_pkg::KEY_VOL_UP].press;
    end

    assign head      = entry_reg[rd_ptr_reg];
    assign room      = (count_reg != DEPTH_C);
    assign out_valid = (count_reg != '0);
    assign push      = tick && (new_entry.mask != '0);
    assign out_fire  = out_valid && out_ready;
    assign sel       = head.mask & (~head.mask + 1'b1);
    assign rest      = head.mask & ~sel;
    assign out_last  = (rest == '0);
    assign pop       = out_fire && out_last;

    always_comb
    begin
        case (sel)
            4'b0001: out_cmd = bdcm_pkg::OP_VOL_DN;
            4'b0010: out_cmd = head.pause_cmd;
            4'b0100: out_cmd = head.play_cmd;
            default: out_cmd = bdcm_pkg::OP_VOL_UP;
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_fire)
        begin
            entry_reg[rd_ptr_reg].mask <= rest;
        end
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= new_entry;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_C)
        else $error("tick queue count beyond depth");

    a_head_has_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0 |-> head.mask != '0)
        else $error("queued tick holds no command");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && !out_last |=> out_valid)
        else $error("command run broken before last");

    a_pop_count: assert property (@(posedge clk) disable iff (!rst_n)
        pop && !push |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue count not decremented on pop");
`endif

endmodule
